### design/assert_macros.svh
// assertion macros for the list engine checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, quiet in reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, quiet in reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### design/dll_pkg.sv
// shared types and codes of the list engine
`default_nettype none
package dll_pkg;
   typedef enum logic [2:0] {
      CMD_PUSH_BACK = 3'd0, CMD_POP_BACK = 3'd1, CMD_POP_FRONT = 3'd2,
      CMD_INSERT = 3'd3, CMD_ERASE = 3'd4, CMD_FIND = 3'd5
   } cmd_type;
   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_FULL = 3'd2, ST_NOTFOUND = 3'd3,
      ST_BADHANDLE = 3'd4
   } status_type;
endpackage
`default_nettype wire

### design/doubly_linked_list_engine.sv
// circular doubly linked list engine with sentinel and free stack
// channel | ports                              | handshake
// req     | req_command req_value req_position | start && !busy accepts
// rsp     | rsp_status rsp_handle rsp_data_out | rsp_strobe, one cycle
//         | rsp_is_empty                       |
// states: an error result goes from S_DECODE straight to S_DONE; push/insert
//   pass through S_WR1, S_WR2 and S_WR3 first, and pop/erase read the node in
//   S_RD1 and S_WAIT1 first; the link memories each have a read and a write port
// find visits one node per pass through S_WALK_RD and S_WALK_CMP, following
//   next_mem, and stops on a hit, at the sentinel or after POOL_NODES nodes
// reset clears links and in_use and fills the free stack in S_CLEAR, a pass
//   over addresses 0..POOL_NODES; busy is high during it
// the receiver cannot stall; busy drops together with the strobe, so the next
//   transaction can be accepted in the strobe cycle
`default_nettype none
module doubly_linked_list_engine #(
   parameter int POOL_NODES = 256,
   parameter int DATA_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [2:0] req_command,
   input  wire logic signed [DATA_BITS-1:0] req_value,
   input  wire logic [$clog2(POOL_NODES+1)-1:0] req_position,
   output logic rsp_strobe,
   output logic [2:0] rsp_status,
   output logic [$clog2(POOL_NODES+1)-1:0] rsp_handle,
   output logic signed [DATA_BITS-1:0] rsp_data_out,
   output logic rsp_is_empty
);
   localparam int HW = $clog2(POOL_NODES+1);
   localparam int FW = $clog2(POOL_NODES);
   localparam logic [HW-1:0] POOL_H = HW'(POOL_NODES);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_RD1, S_WAIT1, S_WR1, S_WR2, S_WR3,
      S_WALK_RD, S_WALK_CMP, S_DONE
   } state_type;

   // memories: links and in_use indexed 0..POOL_NODES, data and free stack
   logic [HW-1:0] next_mem [0:POOL_NODES];
   logic [HW-1:0] prev_mem [0:POOL_NODES];
   logic          use_mem  [0:POOL_NODES];
   logic [DATA_BITS-1:0] data_mem [0:POOL_NODES];
   logic [HW-1:0] free_mem [0:POOL_NODES-1];

   state_type state_ff;
   logic [HW-1:0] clr_ff;
   logic [HW:0]   free_cnt_ff;
   logic [HW-1:0] head_next_ff, head_prev_ff; // sentinel links mirrored
   logic [2:0]    cmd_ff;
   logic [DATA_BITS-1:0] val_ff;
   logic [HW-1:0] pos_ff;
   logic [HW-1:0] h_ff, p_ff, n_ff;
   logic [FW:0]   steps_ff;

   // memory read ports (registered data)
   logic [HW-1:0] rd_addr;
   logic [HW-1:0] nx_q, pv_q;
   logic          use_q;
   logic [DATA_BITS-1:0] dat_q;
   logic [HW-1:0] free_q;
   // write ports
   logic nx_we, pv_we, use_we, dat_we, free_we;
   logic [HW-1:0] nx_wa, pv_wa, use_wa, nx_wd, pv_wd;
   logic use_wd;
   logic [FW-1:0] free_wa;
   logic [HW-1:0] free_wd;

   logic [FW-1:0] free_top;
   assign free_top = FW'(free_cnt_ff - 1'b1);

   always_ff @(posedge clock) begin
      nx_q  <= next_mem[rd_addr];
      pv_q  <= prev_mem[rd_addr];
      use_q <= use_mem[rd_addr];
      dat_q <= data_mem[rd_addr];
      free_q <= free_mem[free_top];
      if (nx_we) next_mem[nx_wa] <= nx_wd;
      if (pv_we) prev_mem[pv_wa] <= pv_wd;
      if (use_we) use_mem[use_wa] <= use_wd;
      if (dat_we) data_mem[h_ff] <= val_ff;
      if (free_we) free_mem[free_wa] <= free_wd;
   end

   logic alloc;
   assign alloc = (cmd_ff == dll_pkg::CMD_PUSH_BACK) || (cmd_ff == dll_pkg::CMD_INSERT);

   // combinational control of memory ports
   always_comb begin
      rd_addr = pos_ff;
      nx_we = 1'b0; pv_we = 1'b0; use_we = 1'b0; dat_we = 1'b0; free_we = 1'b0;
      nx_wa = '0; pv_wa = '0; use_wa = '0; nx_wd = '0; pv_wd = '0; use_wd = 1'b0;
      free_wa = '0; free_wd = '0;
      case (state_ff)
         S_CLEAR: begin
            nx_we = 1'b1; pv_we = 1'b1; use_we = 1'b1;
            nx_wa = clr_ff; pv_wa = clr_ff; use_wa = clr_ff;
            // free stack: entry i holds POOL_NODES - i
            free_we = (clr_ff != POOL_H);
            free_wa = clr_ff[FW-1:0];
            free_wd = POOL_H - clr_ff;
         end
         S_IDLE: rd_addr = req_position;
         S_RD1: rd_addr = h_ff;
         S_WALK_RD: rd_addr = h_ff;
         S_WR1: begin
            if (alloc) begin
               // new node h between p and n
               nx_we = 1'b1; nx_wa = h_ff; nx_wd = n_ff;
               pv_we = 1'b1; pv_wa = h_ff; pv_wd = p_ff;
               use_we = 1'b1; use_wa = h_ff; use_wd = 1'b1;
               dat_we = 1'b1;
            end else begin
               // unlink h: next[p]=n, prev[n]=p
               nx_we = 1'b1; nx_wa = p_ff; nx_wd = n_ff;
               pv_we = 1'b1; pv_wa = n_ff; pv_wd = p_ff;
               use_we = 1'b1; use_wa = h_ff; use_wd = 1'b0;
               free_we = 1'b1;
               free_wa = free_cnt_ff[FW-1:0];
               free_wd = h_ff;
            end
         end
         S_WR2: begin
            if (alloc) begin
               nx_we = 1'b1; nx_wa = p_ff; nx_wd = h_ff;
               pv_we = 1'b1; pv_wa = n_ff; pv_wd = h_ff;
            end else begin
               nx_we = 1'b1; nx_wa = h_ff; nx_wd = '0;
               pv_we = 1'b1; pv_wa = h_ff; pv_wd = '0;
            end
         end
         default: ;
      endcase
   end

   // sentinel links after this command's writes
   logic [HW-1:0] hn_in, hp_in;
   always_comb begin
      hn_in = head_next_ff;
      hp_in = head_prev_ff;
      if (nx_we && nx_wa == '0) hn_in = nx_wd;
      if (pv_we && pv_wa == '0) hp_in = pv_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         free_cnt_ff <= (HW+1)'(POOL_NODES);
         head_next_ff <= '0;
         head_prev_ff <= '0;
         rsp_strobe <= 1'b0;
         busy <= 1'b1;
         steps_ff <= '0;
      end else begin
         rsp_strobe <= 1'b0;
         head_next_ff <= hn_in;
         head_prev_ff <= hp_in;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == POOL_H) begin
                  state_ff <= S_IDLE;
                  busy <= 1'b0;
               end
            end
            S_IDLE: begin
               if (start) begin
                  cmd_ff <= req_command;
                  val_ff <= req_value;
                  pos_ff <= req_position;
                  busy <= 1'b1;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               // use_q/nx_q/pv_q are from pos; free_q is top of stack
               rsp_status <= dll_pkg::ST_OK;
               rsp_handle <= '0;
               rsp_data_out <= '0;
               state_ff <= S_DONE;
               case (cmd_ff)
                  dll_pkg::CMD_PUSH_BACK: begin
                     if (free_cnt_ff == '0) rsp_status <= dll_pkg::ST_FULL;
                     else begin
                        h_ff <= free_q; p_ff <= head_prev_ff; n_ff <= '0;
                        free_cnt_ff <= free_cnt_ff - 1'b1;
                        state_ff <= S_WR1;
                     end
                  end
                  dll_pkg::CMD_INSERT: begin
                     if (pos_ff > POOL_H || (pos_ff != '0 && !use_q))
                        rsp_status <= dll_pkg::ST_BADHANDLE;
                     else if (free_cnt_ff == '0) rsp_status <= dll_pkg::ST_FULL;
                     else begin
                        h_ff <= free_q; p_ff <= pos_ff;
                        n_ff <= (pos_ff == '0) ? head_next_ff : nx_q;
                        free_cnt_ff <= free_cnt_ff - 1'b1;
                        state_ff <= S_WR1;
                     end
                  end
                  dll_pkg::CMD_POP_BACK, dll_pkg::CMD_POP_FRONT: begin
                     if (head_next_ff == '0) rsp_status <= dll_pkg::ST_EMPTY;
                     else begin
                        h_ff <= (cmd_ff == dll_pkg::CMD_POP_BACK) ? head_prev_ff
                                                                  : head_next_ff;
                        state_ff <= S_RD1;
                     end
                  end
                  dll_pkg::CMD_ERASE: begin
                     if (pos_ff == '0 || pos_ff > POOL_H || !use_q)
                        rsp_status <= dll_pkg::ST_BADHANDLE;
                     else begin
                        h_ff <= pos_ff; state_ff <= S_RD1;
                     end
                  end
                  dll_pkg::CMD_FIND: begin
                     rsp_status <= dll_pkg::ST_NOTFOUND;
                     h_ff <= head_next_ff;
                     steps_ff <= '0;
                     state_ff <= S_WALK_RD;
                  end
                  default: rsp_status <= dll_pkg::ST_BADHANDLE;
               endcase
            end
            S_RD1: state_ff <= S_WAIT1;
            S_WAIT1: begin
               // links and data of the node being removed
               p_ff <= pv_q; n_ff <= nx_q;
               rsp_handle <= h_ff;
               rsp_data_out <= dat_q;
               state_ff <= S_WR1;
            end
            S_WR1: begin
               if (!alloc) free_cnt_ff <= free_cnt_ff + 1'b1;
               else rsp_handle <= h_ff;
               state_ff <= S_WR2;
            end
            S_WR2: state_ff <= S_WR3;
            S_WR3: state_ff <= S_DONE;
            S_WALK_RD: begin
               if (h_ff == '0 || h_ff > POOL_H || steps_ff == (FW+1)'(POOL_NODES))
                  state_ff <= S_DONE;
               else state_ff <= S_WALK_CMP;
            end
            S_WALK_CMP: begin
               if (dat_q == val_ff) begin
                  rsp_status <= dll_pkg::ST_OK;
                  rsp_handle <= h_ff;
                  rsp_data_out <= dat_q;
                  state_ff <= S_DONE;
               end else begin
                  h_ff <= nx_q;
                  steps_ff <= steps_ff + 1'b1;
                  state_ff <= S_WALK_RD;
               end
            end
            S_DONE: begin
               rsp_strobe <= 1'b1;
               rsp_is_empty <= (head_next_ff == '0);
               state_ff <= S_IDLE;
               busy <= 1'b0;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

### design/dll_checker.sv
// port-level checker for the list engine, bound to the engine module
`default_nettype none
`include "assert_macros.svh"
module dll_checker #(
   parameter int HW = 9
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe,
   input wire logic [2:0] rsp_status,
   input wire logic [HW-1:0] rsp_handle
);
   `CHK_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised on accept")
   `CHK_IMPL(a_strobe_busy, clock, reset, rsp_strobe, !busy, "busy still high with strobe")
   `CHK_NEXT(a_strobe_once, clock, reset, rsp_strobe, !rsp_strobe, "strobe repeated")
   `CHK_IMPL(a_status_ok, clock, reset, rsp_strobe, rsp_status <= dll_pkg::ST_BADHANDLE, "bad status code")
   `CHK_IMPL(a_fail_handle, clock, reset, rsp_strobe && rsp_status != dll_pkg::ST_OK, rsp_handle == '0, "handle on failed command")
endmodule
bind doubly_linked_list_engine dll_checker #(.HW($clog2(POOL_NODES+1))) u_dll_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_handle(rsp_handle)
);
`default_nettype wire

### bench/tb_top.sv
// self-checking testbench for the doubly linked list engine with a built-in list predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   localparam int POOL = 256;
   localparam int RANDOM_ITEMS = 1400;
   // slowest find walks the whole pool, plus sender gaps
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 20;
   // opcodes beyond the defined set, the block must reject them
   localparam logic [2:0] CMD_UNUSED_A = 3'd6;
   localparam logic [2:0] CMD_UNUSED_B = 3'd7;

   typedef struct {
      logic [2:0] command;
      logic signed [31:0] value;
      logic [8:0] position;
   } list_cmd_type;

   typedef struct {
      dll_pkg::status_type status;
      logic [8:0] handle;
      logic signed [31:0] data;
      logic empty;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_command = '0;
   logic signed [31:0] req_value = '0;
   logic [8:0] req_position = '0;
   logic rsp_strobe;
   logic [2:0] rsp_status;
   logic [8:0] rsp_handle;
   logic signed [31:0] rsp_data_out;
   logic rsp_is_empty;

   doubly_linked_list_engine DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_value(req_value), .req_position(req_position),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_handle(rsp_handle),
      .rsp_data_out(rsp_data_out), .rsp_is_empty(rsp_is_empty)
   );

   always #5 clock = ~clock;

   // shadow copy of the list: pool data, links, in-use flags and free stack
   logic signed [31:0] node_val [1:POOL];
   logic [8:0] next_of [0:POOL];
   logic [8:0] prev_of [0:POOL];
   bit node_live [0:POOL];
   logic [8:0] free_pool [0:POOL-1];
   int free_left;

   // commands waiting for the driver, each with its predicted response
   list_cmd_type cmd_queue[$];
   list_rsp_type cmd_rsp_queue[$];
   // responses owed by the block, oldest first
   list_rsp_type owed_rsp[$];

   bit failed = 1'b0;
   longint cycle_count = 0;
   int burst_left = 8;
   int gap_left = 0;

   // take the top of the free stack for a new node
   function automatic int take_node(logic signed [31:0] v);
      int h;
      free_left--;
      h = int'(free_pool[free_left]);
      node_val[h] = v;
      node_live[h] = 1'b1;
      return h;
   endfunction

   function automatic void splice_after(int p, int h);
      int n;
      n = int'(next_of[p]);
      next_of[h] = 9'(n);
      prev_of[h] = 9'(p);
      prev_of[n] = 9'(h);
      next_of[p] = 9'(h);
   endfunction

   function automatic void release_node(int h);
      int p;
      int n;
      p = int'(prev_of[h]);
      n = int'(next_of[h]);
      next_of[p] = 9'(n);
      prev_of[n] = 9'(p);
      next_of[h] = '0;
      prev_of[h] = '0;
      node_live[h] = 1'b0;
      free_pool[free_left] = 9'(h);
      free_left++;
   endfunction

   // apply one command to the shadow list and return what the block must answer
   function automatic list_rsp_type list_update(list_cmd_type c);
      list_rsp_type r;
      int h;
      int steps;
      bit hit;
      r.status = dll_pkg::ST_OK;
      r.handle = '0;
      r.data = '0;
      case (c.command)
         dll_pkg::CMD_PUSH_BACK, dll_pkg::CMD_INSERT: begin
            if (c.command == dll_pkg::CMD_INSERT &&
                (c.position > POOL || (c.position != 0 && !node_live[c.position]))) begin
               r.status = dll_pkg::ST_BADHANDLE;
            end else if (free_left == 0) begin
               r.status = dll_pkg::ST_FULL;
            end else begin
               h = take_node(c.value);
               splice_after((c.command == dll_pkg::CMD_INSERT) ? int'(c.position)
                                                               : int'(prev_of[0]), h);
               r.handle = 9'(h);
            end
         end
         dll_pkg::CMD_POP_BACK, dll_pkg::CMD_POP_FRONT: begin
            if (next_of[0] == 0) begin
               r.status = dll_pkg::ST_EMPTY;
            end else begin
               h = (c.command == dll_pkg::CMD_POP_BACK) ? int'(prev_of[0]) : int'(next_of[0]);
               r.handle = 9'(h);
               r.data = node_val[h];
               release_node(h);
            end
         end
         dll_pkg::CMD_ERASE: begin
            if (c.position == 0 || c.position > POOL || !node_live[c.position]) begin
               r.status = dll_pkg::ST_BADHANDLE;
            end else begin
               r.handle = c.position;
               r.data = node_val[c.position];
               release_node(int'(c.position));
            end
         end
         dll_pkg::CMD_FIND: begin
            // first match walking forward from the head
            r.status = dll_pkg::ST_NOTFOUND;
            h = int'(next_of[0]);
            hit = 1'b0;
            for (steps = 0; steps < POOL && h != 0 && !hit; steps++) begin
               if (node_val[h] == c.value) begin
                  hit = 1'b1;
                  r.status = dll_pkg::ST_OK;
                  r.handle = 9'(h);
                  r.data = node_val[h];
               end else begin
                  h = int'(next_of[h]);
               end
            end
         end
         default: r.status = dll_pkg::ST_BADHANDLE;
      endcase
      r.empty = (next_of[0] == 0);
      return r;
   endfunction

   // queue a command together with its predicted response
   task automatic add_cmd(logic [2:0] c, logic signed [31:0] v, logic [8:0] p);
      list_cmd_type t;
      t.command = c;
      t.value = v;
      t.position = p;
      cmd_queue.push_back(t);
      cmd_rsp_queue.push_back(list_update(t));
   endtask

   // some live handle, or 0 when the list is empty
   function automatic int any_live();
      int k;
      int i;
      k = $urandom_range(1, POOL);
      for (i = 0; i < POOL; i++) begin
         if (node_live[k]) return k;
         k = (k % POOL) + 1;
      end
      return 0;
   endfunction

   // mix of full-range, small (duplicate-prone) and extreme data values
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 7);
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   // one random command, weighted by how full the list is
   task automatic add_random_cmd();
      int roll;
      int used;
      int h;
      used = POOL - free_left;
      roll = $urandom_range(0, 99);
      // keep the list short most of the time so finds stay cheap
      if (used > 48 && roll < 28) roll = 40;
      if (used > 48 && roll >= 48 && roll < 65) roll = 70;
      if (roll < 28) begin
         add_cmd(dll_pkg::CMD_PUSH_BACK, pick_value(), 9'($urandom));
      end else if (roll < 38) begin
         add_cmd(dll_pkg::CMD_POP_BACK, $urandom, 9'($urandom));
      end else if (roll < 48) begin
         add_cmd(dll_pkg::CMD_POP_FRONT, $urandom, 9'($urandom));
      end else if (roll < 65) begin
         h = any_live();
         if ($urandom_range(0, 99) < 15) h = 0;
         else if ($urandom_range(0, 99) < 20 || h == 0) h = $urandom_range(0, 511);
         add_cmd(dll_pkg::CMD_INSERT, pick_value(), 9'(h));
      end else if (roll < 80) begin
         h = any_live();
         if ($urandom_range(0, 99) < 20 || h == 0) h = $urandom_range(0, 511);
         add_cmd(dll_pkg::CMD_ERASE, $urandom, 9'(h));
      end else if (roll < 95) begin
         h = any_live();
         add_cmd(dll_pkg::CMD_FIND,
                 (h != 0 && $urandom_range(0, 99) < 60) ? node_val[h] : pick_value(),
                 9'($urandom));
      end else begin
         add_cmd($urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B, $urandom, 9'($urandom));
      end
   endtask

   // driver: new values at the falling edge, bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (gap_left > 0) begin
         start <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
         start <= 1'b1;
         req_command <= cmd_queue[0].command;
         req_value <= cmd_queue[0].value;
         req_position <= cmd_queue[0].position;
      end else begin
         start <= 1'b0;
      end
   end

   // acceptance and response check at the rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d commands and %0d responses outstanding",
                  $time, cmd_queue.size(), owed_rsp.size());
         $display("tb_top NOT OK");
         $finish;
      end
      if (!reset && start && !busy && cmd_queue.size() > 0) begin
         // transaction accepted: its response is now owed
         owed_rsp.push_back(cmd_rsp_queue.pop_front());
         void'(cmd_queue.pop_front());
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            // zero gap sometimes so back-to-back commands also happen
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
      end
      if (!reset && rsp_strobe) begin
         if (owed_rsp.size() == 0) begin
            $display("%0t unexpected response: status %0d handle %0d data %0d",
                     $time, rsp_status, rsp_handle, rsp_data_out);
            failed = 1'b1;
         end else begin
            list_rsp_type e;
            e = owed_rsp.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t status: expected %0d, actual %0d", $time, e.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_handle !== e.handle) begin
               $display("%0t handle: expected %0d, actual %0d", $time, e.handle, rsp_handle);
               failed = 1'b1;
            end
            if (rsp_data_out !== e.data) begin
               $display("%0t data_out: expected %0d, actual %0d", $time, e.data, rsp_data_out);
               failed = 1'b1;
            end
            if (rsp_is_empty !== e.empty) begin
               $display("%0t is_empty: expected %0d, actual %0d", $time, e.empty, rsp_is_empty);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      int i;
      int h;
      // shadow list starts like the block after reset
      for (i = 0; i <= POOL; i++) begin
         next_of[i] = '0;
         prev_of[i] = '0;
         node_live[i] = 1'b0;
      end
      for (i = 1; i <= POOL; i++) node_val[i] = '0;
      for (i = 0; i < POOL; i++) free_pool[i] = 9'(POOL - i);
      free_left = POOL;

      // directed: empty-list pops and find, bad handles, unused opcodes
      add_cmd(dll_pkg::CMD_POP_BACK, 0, 0);
      add_cmd(dll_pkg::CMD_POP_FRONT, 0, 0);
      add_cmd(dll_pkg::CMD_FIND, 0, 0);
      add_cmd(dll_pkg::CMD_ERASE, 0, 0);
      add_cmd(dll_pkg::CMD_ERASE, 5, 9'd257);
      add_cmd(dll_pkg::CMD_INSERT, 1, 9'd511);
      add_cmd(dll_pkg::CMD_INSERT, 1, 9'd7);
      add_cmd(CMD_UNUSED_A, -1, 9'd511);
      add_cmd(CMD_UNUSED_B, 0, 0);
      // directed: extreme values, insert at the head, first-match find
      add_cmd(dll_pkg::CMD_PUSH_BACK, 32'sh7fffffff, 0);
      add_cmd(dll_pkg::CMD_PUSH_BACK, 32'sh80000000, 9'd511);
      add_cmd(dll_pkg::CMD_INSERT, -1, 0);
      add_cmd(dll_pkg::CMD_INSERT, 0, 9'd1);
      add_cmd(dll_pkg::CMD_INSERT, 32'sh80000000, 9'd256);
      add_cmd(dll_pkg::CMD_FIND, 32'sh80000000, 0);
      add_cmd(dll_pkg::CMD_FIND, 12345, 0);
      add_cmd(dll_pkg::CMD_ERASE, 0, 9'd1);
      add_cmd(dll_pkg::CMD_ERASE, 0, 9'd1);
      add_cmd(dll_pkg::CMD_POP_FRONT, 0, 0);
      add_cmd(dll_pkg::CMD_POP_BACK, 0, 0);
      add_cmd(dll_pkg::CMD_POP_BACK, 0, 0);
      add_cmd(dll_pkg::CMD_POP_BACK, 0, 0);

      // random, with one pass that fills the pool to the brim and drains it to ten nodes
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            while (free_left > 0) add_cmd(dll_pkg::CMD_PUSH_BACK, pick_value(), 9'($urandom));
            add_cmd(dll_pkg::CMD_PUSH_BACK, 1, 0);
            add_cmd(dll_pkg::CMD_INSERT, 2, 0);
            add_cmd(dll_pkg::CMD_INSERT, 3, 9'(any_live()));
            add_cmd(dll_pkg::CMD_INSERT, 4, 9'd300);
            add_cmd(dll_pkg::CMD_FIND, 32'sh13572468, 0);
            h = any_live();
            add_cmd(dll_pkg::CMD_FIND, node_val[h], 0);
            add_cmd(dll_pkg::CMD_ERASE, 0, 9'(any_live()));
            add_cmd(dll_pkg::CMD_INSERT, 5, 9'd256);
            while (POOL - free_left > 10)
               add_cmd($urandom_range(0, 1) ? dll_pkg::CMD_POP_BACK : dll_pkg::CMD_POP_FRONT,
                       0, 0);
         end
         add_random_cmd();
      end

      // reset once at the start; the block then clears its pool with busy high
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (cmd_queue.size() == 0 && owed_rsp.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && owed_rsp.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire

### doubly_linked_list_engine.f
+incdir+design
design/dll_pkg.sv
design/doubly_linked_list_engine.sv
design/dll_checker.sv
bench/tb_top.sv
